// ===== hdl/msp_pkg.sv =====
// Shared types and codes for the multi-stack shared pool.
// Used by the top level, msp_pool and the testbench; depends on nothing.
package msp_pkg;

  // Action codes of a request. The unused code behaves as a peek.
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         stack_id;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_e            status;
    logic               stack_empty;
  } rsp_t;

  // Control group from the sequencer to the pool.
  typedef struct packed {
    logic lookup;    // read link and value memories this cycle
    logic use_free;  // read at the free-list head instead of the stack top
    logic push;      // commit a push
    logic pop;       // commit a pop
  } pool_cmd_t;

endpackage

// ===== hdl/multi_stack_shared_pool_top.sv =====
// Top level of the multi-stack shared pool: request sequencer and config register.
// Depends on msp_pkg, msp_tops and msp_pool.
//
// Several LIFO stacks share one pool of ENTRIES value slots. Free slots are
// chained through a next-link memory behind a free-list head; each stack has
// a top pointer and each of its slots links to the slot below.
// Requests: a beat on req_i is taken at a rising edge with start high and
// busy low. Each request gives exactly one result beat on rsp_o, marked by
// rsp_valid_o for one cycle; the receiver cannot stall it.
// Timing: the result is on rsp_o in the FSM_EXEC state, after FSM_LOOKUP, and
// is taken at the edge that ends it. Busy stays high through that cycle, so a
// new request is taken only after the result of the last one has been given.
// The accepting edge reads the top-pointer memory, the FSM_LOOKUP state reads
// the link and value memories at the address it gives, and the result cycle
// writes back; the idle cycle keeps the next top read clear of that write.
// Configuration: cfg_data_i sets the number of active stacks whenever
// cfg_valid_i is high (cfg_ready_o is always high); write it only while idle.
// Reset: every stack is empty, the free list runs through the slots in index
// order and active stacks is 16. No clearing pass is needed: never used slots
// are tracked by a fill count, so the block takes requests right after reset.
module multi_stack_shared_pool_top
  import msp_pkg::*;
#(
  parameter int unsigned ENTRIES     = 128,
  parameter int unsigned MAX_STACKS  = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned IW = (SW > 4) ? SW : 4;
  localparam int unsigned XW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  fsm_e             state_q, state_d;
  req_t             req_q;
  logic             bad_q;
  logic [SW-1:0]    idx_q;
  logic [CFG_W-1:0] active_q;

  logic             accept;
  logic             bad_in;
  logic [IW-1:0]    sid_wide;
  logic [SW-1:0]    idx_in;

  logic [AW:0]      top_link;
  logic             top_nil;
  logic             tops_rd, tops_wr;
  logic [AW:0]      tops_wr_link;

  pool_cmd_t        pool_cmd;
  logic             free_nil;
  logic [AW-1:0]    free_addr;
  logic [AW:0]      link_rd;
  logic [VALUE_WIDTH-1:0] value_rd;

  logic signed [XW-1:0] rd_ext;
  logic signed [XW-1:0] push_ext;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != FSM_IDLE);
  assign accept      = start && !busy;

  // Stack numbers at or above the active count or the table depth are rejected.
  assign bad_in   = ({1'b0, req_i.stack_id} >= active_q) ||
                    (32'(req_i.stack_id) >= MAX_STACKS);
  assign sid_wide = IW'(req_i.stack_id);
  assign idx_in   = sid_wide[SW-1:0];

  assign top_nil  = top_link[AW];
  assign tops_rd  = accept;

  // A stored value is sign-extended from its width before it is cut to 32 bits.
  assign rd_ext   = XW'($signed(value_rd));
  assign push_ext = XW'(req_q.push_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      active_q <= ACTIVE_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      bad_q <= bad_in;
      idx_q <= idx_in;
    end
  end

  always_comb begin
    state_d           = state_q;
    pool_cmd          = '0;
    tops_wr           = 1'b0;
    tops_wr_link      = link_rd;
    rsp_valid_o       = 1'b0;
    rsp_o.read_value  = '0;
    rsp_o.status      = ST_OK;
    rsp_o.stack_empty = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_LOOKUP;
        end
      end
      FSM_LOOKUP: begin
        // The top pointer is now known; fetch the slot a push, pop or peek needs.
        pool_cmd.lookup   = 1'b1;
        pool_cmd.use_free = (req_q.action == ACT_PUSH);
        state_d           = FSM_EXEC;
      end
      FSM_EXEC: begin
        rsp_valid_o = 1'b1;
        state_d     = FSM_IDLE;
        if (bad_q) begin
          rsp_o.status = ST_BAD;
        end else if (req_q.action == ACT_PUSH) begin
          if (free_nil) begin
            rsp_o.status      = ST_FULL;
            rsp_o.stack_empty = top_nil;
          end else begin
            pool_cmd.push = 1'b1;
            tops_wr       = 1'b1;
            tops_wr_link  = {1'b0, free_addr};
          end
        end else if (top_nil) begin
          rsp_o.status      = ST_EMPTY;
          rsp_o.stack_empty = 1'b1;
        end else begin
          rsp_o.read_value = rd_ext[31:0];
          if (req_q.action == ACT_POP) begin
            pool_cmd.pop      = 1'b1;
            tops_wr           = 1'b1;
            tops_wr_link      = link_rd;
            rsp_o.stack_empty = link_rd[AW];
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  msp_tops #(
    .MAX_STACKS(MAX_STACKS),
    .ENTRIES   (ENTRIES)
  ) u_tops (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (tops_rd),
    .rd_idx_i (idx_in),
    .wr_en_i  (tops_wr),
    .wr_idx_i (idx_q),
    .wr_link_i(tops_wr_link),
    .top_o    (top_link)
  );

  msp_pool #(
    .ENTRIES    (ENTRIES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pool_cmd),
    .top_addr_i (top_link[AW-1:0]),
    .top_link_i (top_link),
    .value_i    (push_ext[VALUE_WIDTH-1:0]),
    .free_nil_o (free_nil),
    .free_addr_o(free_addr),
    .link_o     (link_rd),
    .value_o    (value_rd)
  );

endmodule

// ===== hdl/msp_tops.sv =====
// Top-pointer table: one link per stack in a synchronous memory with valid bits.
// Depends on msp_pkg only by convention; uses no package items.
module msp_tops #(
  parameter int unsigned MAX_STACKS = 16,
  parameter int unsigned ENTRIES    = 128,
  localparam int unsigned AW = $clog2(ENTRIES),
  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [SW-1:0] rd_idx_i,
  input  logic          wr_en_i,
  input  logic [SW-1:0] wr_idx_i,
  input  logic [AW:0]   wr_link_i,
  output logic [AW:0]   top_o
);

  logic [AW:0]           mem [MAX_STACKS];
  logic [MAX_STACKS-1:0] vld_q;
  logic [AW:0]           rd_q;
  logic                  rd_vld_q;

  // Bit AW of a link marks null; a stack without a valid bit reads as null.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_link_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign top_o = rd_vld_q ? rd_q : {1'b1, {AW{1'b0}}};

endmodule

// ===== hdl/msp_pool.sv =====
// Shared pool: next-link and value memories, free-list head and fill count.
// Depends on msp_pkg for the pool command struct.
module msp_pool
  import msp_pkg::*;
#(
  parameter int unsigned ENTRIES     = 128,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pool_cmd_t              cmd_i,
  input  logic [AW-1:0]          top_addr_i,
  input  logic [AW:0]            top_link_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   free_nil_o,
  output logic [AW-1:0]          free_addr_o,
  output logic [AW:0]            link_o,
  output logic [VALUE_WIDTH-1:0] value_o
);

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic [AW:0]            link_mem [ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem  [ENTRIES];

  logic [AW:0]   free_q, free_d;
  logic [AW:0]   fresh_q, fresh_d;
  logic [AW:0]   link_rd_q;
  logic [AW:0]   fresh_link_q;
  logic          fresh_rd_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [AW:0]   wdata;

  assign free_nil_o  = free_q[AW];
  assign free_addr_o = free_q[AW-1:0];
  assign raddr       = cmd_i.use_free ? free_q[AW-1:0] : top_addr_i;

  // Entries at or above the fill count were never linked; their link is the
  // reset chain to the next index, and the last one is null.
  assign link_o = fresh_rd_q ? fresh_link_q : link_rd_q;

  assign waddr = cmd_i.push ? free_q[AW-1:0] : top_addr_i;
  assign wdata = cmd_i.push ? top_link_i : free_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      link_rd_q    <= link_mem[raddr];
      value_o      <= val_mem[raddr];
      fresh_rd_q   <= ({1'b0, raddr} >= fresh_q);
      fresh_link_q <= (raddr == LAST) ? {1'b1, {AW{1'b0}}} : {1'b0, raddr + AW'(1)};
    end
    if (cmd_i.push || cmd_i.pop) begin
      link_mem[waddr] <= wdata;
    end
    if (cmd_i.push) begin
      val_mem[free_q[AW-1:0]] <= value_i;
    end
  end

  always_comb begin
    free_d  = free_q;
    fresh_d = fresh_q;
    if (cmd_i.push) begin
      free_d = link_o;
      if (fresh_rd_q) begin
        fresh_d = fresh_q + (AW+1)'(1);
      end
    end else if (cmd_i.pop) begin
      free_d = {1'b0, top_addr_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '0;
      fresh_q <= '0;
    end else begin
      free_q  <= free_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

// ===== verif/msp_scoreboard_pkg.sv =====
// Scoreboard for the multi-stack shared pool testbench: a behavioral copy of the
// pool (stack tops, link chain, values, free head) and a queue of predicted results.
// Depends on msp_pkg for the request and result types and the status codes.
package msp_scoreboard_pkg;
  import msp_pkg::*;

  localparam int unsigned POOL_SLOTS  = 128;
  localparam int unsigned STACK_SLOTS = 16;

  typedef logic [7:0] slot_t;
  localparam slot_t NIL_SLOT = 8'hFF;

  class pool_tracker;
    slot_t              top_of   [STACK_SLOTS];
    slot_t              link_of  [POOL_SLOTS];
    logic signed [31:0] value_of [POOL_SLOTS];
    slot_t              free_head;
    logic [CFG_W-1:0]   active;
    rsp_t               pending_rsp [$];
    int unsigned        mismatches;
    int unsigned        strays;
    int unsigned        cfg_writes;
    int unsigned        status_seen [4];

    function new();
      for (int i = 0; i < STACK_SLOTS; i++) top_of[i] = NIL_SLOT;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        link_of[i]  = (i + 1 < POOL_SLOTS) ? slot_t'(i + 1) : NIL_SLOT;
        value_of[i] = '0;
      end
      free_head  = '0;
      active     = ACTIVE_RESET;
      mismatches = 0;
      strays     = 0;
      cfg_writes = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_active(logic [CFG_W-1:0] v);
      active = v;
      cfg_writes++;
    endfunction

    // Apply one request to the copy of the pool and return the result it gives.
    function rsp_t predict_outcome(req_t r);
      rsp_t  o;
      int    lim;
      slot_t t;
      slot_t e;
      slot_t nf;
      slot_t below;
      o.read_value  = '0;
      o.status      = ST_OK;
      o.stack_empty = 1'b0;
      lim = (int'(active) < STACK_SLOTS) ? int'(active) : STACK_SLOTS;
      if (int'(r.stack_id) >= lim) begin
        o.status = ST_BAD;
        return o;
      end
      t = top_of[r.stack_id];
      if (t >= POOL_SLOTS) t = NIL_SLOT;
      if (r.action == ACT_PUSH) begin
        e = free_head;
        if (e >= POOL_SLOTS) begin
          o.status      = ST_FULL;
          o.stack_empty = (t == NIL_SLOT);
        end else begin
          nf                  = link_of[e];
          free_head           = (nf >= POOL_SLOTS) ? NIL_SLOT : nf;
          link_of[e]          = t;
          top_of[r.stack_id]  = e;
          value_of[e]         = r.push_value;
        end
      end else if (t == NIL_SLOT) begin
        o.status      = ST_EMPTY;
        o.stack_empty = 1'b1;
      end else if (r.action == ACT_POP) begin
        below              = link_of[t];
        o.read_value       = value_of[t];
        top_of[r.stack_id] = (below >= POOL_SLOTS) ? NIL_SLOT : below;
        link_of[t]         = free_head;
        free_head          = t;
        o.stack_empty      = (top_of[r.stack_id] == NIL_SLOT);
      end else begin
        // Peek, and the undecoded action code, which behaves as a peek.
        o.read_value = value_of[t];
      end
      return o;
    endfunction

    function void note_request(req_t r);
      rsp_t o;
      o = predict_outcome(r);
      status_seen[o.status]++;
      pending_rsp.push_back(o);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("%0t: result beat with nothing outstanding: value %h status %0d empty %0b",
                   $time, got.read_value, got.status, got.stack_empty);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.stack_empty !== want.stack_empty) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("%0t: mismatch: value %h/%h status %0d/%0d empty %0b/%0b (exp/got)",
                   $time, want.read_value, got.read_value, want.status, got.status,
                   want.stack_empty, got.stack_empty);
      end
    endfunction

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction

    function int unsigned failures();
      return mismatches + strays + pending_rsp.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_multi_stack_shared_pool_top.sv =====
// Testbench for multi_stack_shared_pool_top: directed and random push, pop and peek
// requests checked against a scoreboard. Depends on msp_pkg and msp_scoreboard_pkg.
module tb_multi_stack_shared_pool_top;
  import msp_pkg::*;
  import msp_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // The fourth action code is not decoded by the block; it must act as a peek.
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  req_t             req_i       = '0;
  logic             rsp_valid_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  pool_tracker      sb;
  int unsigned      idle_pct;
  int unsigned      idle_cycles;

  multi_stack_shared_pool_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Monitor. Every input is driven with nonblocking assignments at the rising
  // edge and the block's outputs come from its flops, so reading them here sees
  // the values that were stable during the cycle ending at this edge. The result
  // check runs before the request is noted so that a result is always matched
  // against requests accepted at earlier edges.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
      if (cfg_valid_i && cfg_ready_o) sb.set_active(cfg_data_i);
    end
  end

  // Watchdog. A cycle in which no request, result or register beat is taken
  // counts toward the limit; any beat clears the count.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || rsp_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog expired: no beat for %0d cycles.", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic req_t mk_req(logic [1:0] act, logic [3:0] sid, logic signed [31:0] val);
    req_t r;
    r.action     = act;
    r.stack_id   = sid;
    r.push_value = val;
    return r;
  endfunction

  // Offer one request and hold it until the block takes it. The task is entered
  // at a rising edge and returns at the edge that accepted the beat. When the
  // sender idles, start drops in this step and rises again only at a later
  // edge, so start never gets two assignments in the same step.
  task automatic send_req(input req_t r);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back, then let
  // the settle cycles pass; the last write back is done at the edge of its result.
  task automatic drain(input int unsigned settle);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle and nothing outstanding.
  task automatic write_active(input logic [CFG_W-1:0] v);
    drain(4);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase. Most requests address an enabled stack so that the pool
  // really fills and empties; the rest pick any stack number, which exercises
  // the bad-stack path. The push share steers the pool toward full or empty.
  task automatic run_phase(input logic [CFG_W-1:0] act, input int unsigned idle,
                           input int unsigned push_pct, input int unsigned count);
    int unsigned        lim;
    int unsigned        roll;
    logic [1:0]         op;
    logic [3:0]         sid;
    logic signed [31:0] val;
    write_active(act);
    idle_pct = idle;
    lim = (act > STACK_SLOTS) ? STACK_SLOTS : act;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < push_pct)
        op = ACT_PUSH;
      else if (roll < push_pct + (100 - push_pct) / 2)
        op = ACT_POP;
      else
        op = ($urandom_range(7) == 0) ? ACT_UNUSED : ACT_PEEK;
      if (lim != 0 && $urandom_range(9) != 0)
        sid = 4'($urandom_range(lim - 1));
      else
        sid = 4'($urandom_range(15));
      case ($urandom_range(15))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = -32'sd1;
        3:       val = '0;
        default: val = $urandom;
      endcase
      send_req(mk_req(op, sid, val));
      // Now and then, and once in the middle of every phase, the sender holds
      // off until the block has answered everything it took.
      if (k == count / 2 || $urandom_range(99) < 2) drain(0);
    end
  endtask

  initial begin
    sb       = new();
    idle_pct = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. After reset all sixteen stacks are enabled and empty.
    send_req(mk_req(ACT_POP,    4'd0,  32'sd5));          // pop of an empty stack
    send_req(mk_req(ACT_PEEK,   4'd15, 32'sd0));          // peek of an empty stack
    send_req(mk_req(ACT_UNUSED, 4'd0,  32'sd0));          // undecoded action, empty
    send_req(mk_req(ACT_PUSH,   4'd0,  32'sh7FFF_FFFF));
    send_req(mk_req(ACT_PUSH,   4'd0,  32'sh8000_0000));
    send_req(mk_req(ACT_PEEK,   4'd0,  32'sd0));
    send_req(mk_req(ACT_UNUSED, 4'd0,  -32'sd1));         // undecoded action acts as peek
    send_req(mk_req(ACT_PUSH,   4'd15, -32'sd1));
    send_req(mk_req(ACT_PUSH,   4'd15, 32'sd100));
    send_req(mk_req(ACT_POP,    4'd15, 32'sd0));
    send_req(mk_req(ACT_POP,    4'd15, 32'sd0));          // last entry leaves the stack
    send_req(mk_req(ACT_POP,    4'd15, 32'sd0));          // empty again
    send_req(mk_req(ACT_PUSH,   4'd7,  32'sd0));          // reuses slots freed above
    send_req(mk_req(ACT_POP,    4'd0,  32'sd0));

    // One enabled stack: stack 0 still holds its entry, the others are rejected.
    write_active(5'd1);
    send_req(mk_req(ACT_PEEK,   4'd0,  32'sd0));
    send_req(mk_req(ACT_PUSH,   4'd1,  32'sd9));
    send_req(mk_req(ACT_POP,    4'd15, 32'sd0));

    // No enabled stack rejects every stack number.
    write_active(5'd0);
    send_req(mk_req(ACT_PUSH,   4'd0,  32'sd1));
    send_req(mk_req(ACT_PEEK,   4'd0,  32'sd0));

    // A count above the stack total acts as the total; stack 7 kept its entry.
    write_active(5'd31);
    send_req(mk_req(ACT_PEEK,   4'd7,  32'sd0));
    send_req(mk_req(ACT_POP,    4'd7,  32'sd0));
    send_req(mk_req(ACT_POP,    4'd15, 32'sd0));

    // Random phases. The push-heavy ones run the pool into full; the pop-heavy
    // ones drain it again. Sender idling cycles through none, 63 and 14 percent.
    run_phase(5'd16, 0,  80, 150);
    run_phase(5'd16, 63, 15, 150);
    run_phase(5'd1,  14, 50, 150);
    run_phase(5'd31, 0,  85, 150);
    run_phase(5'd16, 14, 90, 100);
    run_phase(5'd0,  14, 50, 40);
    run_phase(5'($urandom_range(16, 1)), 63, 20, 150);
    run_phase(5'($urandom_range(31)),    0,  50, 150);
    run_phase(5'd16, 14, 10, 100);

    // Let every outstanding result arrive, then watch a little longer for
    // result beats that nothing asked for.
    drain(8);

    $display("Checked %0d requests: %0d ok, %0d empty, %0d full, %0d bad stack.",
             sb.status_seen[ST_OK] + sb.status_seen[ST_EMPTY] + sb.status_seen[ST_FULL] +
             sb.status_seen[ST_BAD], sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], sb.status_seen[ST_BAD]);
    $display("Active stack count written %0d times; %0d mismatches, %0d stray results.",
             sb.cfg_writes, sb.mismatches, sb.strays);
    if (sb.failures() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
